// ----- sv/tscs_pkg.sv -----
`timescale 1ns / 1ps
package tscs_pkg;

    // Default parameter values
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int QUEUE_DEPTH     = 2;

    // Fixed field widths
    localparam int CH_W     = 3;
    localparam int KNOB_W   = 17;
    localparam int FACTOR_W = 17;
    localparam int MODE_W   = 2;
    localparam int LAMP_W   = 8;
    localparam int TGT_W    = 16;
    localparam int SMOOTH_W = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    // Fixed-point constants (1/2048 V units, Q1.16 fractions)
    localparam logic [KNOB_W-1:0] ONE_Q16 = 17'd65536;
    localparam int TRIG_THRESHOLD = 2048;
    localparam int OUT_LIMIT      = 20480;

    // Range modes
    localparam logic [MODE_W-1:0] MODE_UNIPOLAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIPOLAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNIT     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING  = 1'b1;

    // Queue status between the job queue and its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ----- sv/tscs_fifo.sv -----
`timescale 1ns / 1ps
module tscs_fifo
    import tscs_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output fifo_status_t     status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr = wr_en && !status.full;
    assign do_rd = rd_en && !status.empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- sv/tscs_front.sv -----
`timescale 1ns / 1ps
module tscs_front
    import tscs_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [CH_W-1:0]               channel,
    input  logic signed [SAMPLE_BITS-1:0] trigger_level,
    input  logic signed [SAMPLE_BITS-1:0] cv_level,
    input  logic                          cv_present,
    input  logic [KNOB_W-1:0]             knob_level,
    input  logic                          frame_end,
    input  fifo_status_t                  q_status,
    output logic                          full,
    output logic                          job_push,
    output logic [CH_W+1+KNOB_W+SAMPLE_BITS-1:0] job_data
);

    localparam int IDX_W = $clog2(CHANNELS);

    // Per-channel stores, no reset
    logic [SAMPLE_BITS-1:0] cv_mem      [CHANNELS];
    logic                   present_mem [CHANNELS];
    logic [KNOB_W-1:0]      knob_mem    [CHANNELS];

    logic [CH_W-1:0]  active_reg, active_next;
    logic             best_valid_reg, best_valid_next;
    logic [CH_W-1:0]  best_reg, best_next;

    logic             accept;
    logic             ch_ok;
    logic             hit;
    logic             best_valid_now;
    logic [CH_W-1:0]  best_now;
    logic [CH_W-1:0]  new_active;
    logic [IDX_W-1:0] wr_idx, rd_idx;
    logic             bypass;
    logic [SAMPLE_BITS-1:0] sel_cv;
    logic             sel_present;
    logic [KNOB_W-1:0] sel_knob;

    assign full   = q_status.full;
    assign accept = push && !full;
    assign ch_ok  = (32'(channel) < CHANNELS);
    assign wr_idx = IDX_W'(channel);

    // Highest triggered channel of the frame so far, this item included
    assign hit = ch_ok && (trigger_level > TRIG_THRESHOLD)
                 && (!best_valid_reg || (channel > best_reg));
    assign best_valid_now = best_valid_reg || hit;
    assign best_now       = hit ? channel : best_reg;
    assign new_active     = best_valid_now ? best_now : active_reg;
    assign rd_idx         = IDX_W'(new_active);

    // Read the active entry, forwarding the item being stored
    assign bypass      = ch_ok && (channel == new_active);
    assign sel_cv      = bypass ? cv_level   : cv_mem[rd_idx];
    assign sel_present = bypass ? cv_present : present_mem[rd_idx];
    assign sel_knob    = bypass ? knob_level : knob_mem[rd_idx];

    assign job_push = accept && frame_end;
    assign job_data = {new_active, sel_present, sel_knob, sel_cv};

    // Frame tracking
    always_comb
    begin
        active_next     = active_reg;
        best_valid_next = best_valid_reg;
        best_next       = best_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                active_next     = new_active;
                best_valid_next = 1'b0;
                best_next       = '0;
            end
            else
            begin
                best_valid_next = best_valid_now;
                best_next       = best_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            best_valid_reg <= 1'b0;
            best_reg       <= '0;
        end
        else
        begin
            active_reg     <= active_next;
            best_valid_reg <= best_valid_next;
            best_reg       <= best_next;
        end
    end

    // Store writes
    always_ff @(posedge clk)
    begin
        if (accept && ch_ok)
        begin
            cv_mem[wr_idx]      <= cv_level;
            present_mem[wr_idx] <= cv_present;
            knob_mem[wr_idx]    <= knob_level;
        end
    end

endmodule

// ----- sv/tscs_back.sv -----
`timescale 1ns / 1ps
module tscs_back
    import tscs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  fifo_status_t                  q_status,
    input  logic [CH_W+1+KNOB_W+SAMPLE_BITS-1:0] job_data,
    output logic                          job_take,
    input  logic [MODE_W-1:0]             range_mode,
    input  logic [FACTOR_W-1:0]           smoothing_factor,
    input  logic                          pop,
    output logic                          empty,
    output logic signed [SAMPLE_BITS-1:0] out_level,
    output logic [CH_W-1:0]               active_channel,
    output logic [LAMP_W-1:0]             lamp_mask
);

    localparam int PROD_W  = KNOB_W + 1 + SAMPLE_BITS;
    localparam int DIFF_W  = SMOOTH_W + 1;
    localparam int SLEW_W  = DIFF_W + FACTOR_W + 1;
    localparam int SUM_W   = SMOOTH_W + 4;
    localparam int Q_W     = 19;
    localparam int RECIP_W = 20;
    localparam logic [RECIP_W-1:0] RECIP5 = 20'd838861;   // ceil(2^22 / 5)
    localparam logic signed [PROD_W-1:0] Q_MAX = PROD_W'(327684);
    localparam logic signed [SUM_W-1:0] S_MAX = SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0] S_MIN = SUM_W'(-64'sh8000_0000);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_TGT  = 3'd3;
    localparam logic [2:0] ST_SLEW = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;

    // Job registers
    logic [CH_W-1:0]               sel_reg;
    logic                          present_reg;
    logic [KNOB_W-1:0]             k_reg;
    logic signed [SAMPLE_BITS-1:0] cv_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic [KNOB_W-1:0]             v_reg;
    logic signed [TGT_W-1:0]       target_reg;
    logic signed [SLEW_W-1:0]      slew_reg;
    logic signed [SMOOTH_W-1:0]    s_reg, s_next;

    // Output slot
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_level_reg;
    logic [CH_W-1:0]               out_ch_reg;
    logic [LAMP_W-1:0]             out_lamp_reg;

    logic [CH_W-1:0]               job_sel;
    logic                          job_present;
    logic [KNOB_W-1:0]             job_knob;
    logic [SAMPLE_BITS-1:0]        job_cv;

    logic signed [PROD_W-1:0]      q;
    logic [Q_W+RECIP_W-1:0]        quot;
    logic [KNOB_W-1:0]             v_calc;
    logic [19:0]                   v5;
    logic [17:0]                   v_unit;
    logic signed [TGT_W-1:0]       t_uni;
    logic signed [TGT_W-1:0]       target_calc;
    logic [FACTOR_W-1:0]           f_sat;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SLEW_W-1:0]      slew_calc;
    logic signed [SLEW_W-1:0]      step;
    logic signed [SUM_W-1:0]       sum;
    logic signed [SMOOTH_W-1:0]    s_sat;
    logic signed [SMOOTH_W:0]      o_round;
    logic signed [16:0]            o17;
    logic signed [TGT_W-1:0]       o_clamp;
    logic                          slot_free;
    logic                          finish;

    assign {job_sel, job_present, job_knob, job_cv} = job_data;
    assign job_take  = (state_reg == ST_IDLE) && !q_status.empty;
    assign slot_free = !out_valid_reg || pop;
    assign finish    = (state_reg == ST_OUT) && slot_free;

    // CV scaling: floor(k*cv / 20480) as floor(floor(k*cv / 4096) / 5), clamped 0..1
    assign q    = prod_reg >>> 12;
    assign quot = (Q_W + RECIP_W)'(q[Q_W-1:0]) * (Q_W + RECIP_W)'(RECIP5);
    always_comb
    begin
        if (q < 0)
        begin
            v_calc = '0;
        end
        else if (q > Q_MAX)
        begin
            v_calc = ONE_Q16;
        end
        else
        begin
            v_calc = quot[22 +: KNOB_W];
        end
    end

    // Range scaling
    assign v5     = (20'(v_reg) << 2) + 20'(v_reg) + 20'd8;
    assign v_unit = 18'(v_reg) + 18'd16;
    assign t_uni  = $signed(v5[19:4]);
    always_comb
    begin
        case (range_mode)
            MODE_BIPOLAR: target_calc = t_uni - 16'sd10240;
            MODE_UNIT:    target_calc = $signed(16'(v_unit[17:5]));
            default:      target_calc = t_uni;
        endcase
    end

    // One-pole step
    assign f_sat     = (smoothing_factor > ONE_Q16) ? ONE_Q16 : smoothing_factor;
    assign diff      = $signed({{(DIFF_W - TGT_W - 16){target_reg[TGT_W-1]}},
                                target_reg, 16'b0}) - DIFF_W'(s_reg);
    assign slew_calc = diff * $signed({1'b0, f_sat});

    // New smoothed value, saturated, then rounded to the output grid
    assign step = slew_reg >>> 16;
    assign sum  = SUM_W'(s_reg) + $signed(step[SUM_W-1:0]);
    always_comb
    begin
        if (sum > S_MAX)
        begin
            s_sat = S_MAX[SMOOTH_W-1:0];
        end
        else if (sum < S_MIN)
        begin
            s_sat = S_MIN[SMOOTH_W-1:0];
        end
        else
        begin
            s_sat = sum[SMOOTH_W-1:0];
        end
    end
    assign o_round = (SMOOTH_W + 1)'(s_sat) + (SMOOTH_W + 1)'(32768);
    assign o17     = $signed(o_round[SMOOTH_W:16]);
    always_comb
    begin
        if (o17 > 17'sd20480)
        begin
            o_clamp = 16'sd20480;
        end
        else if (o17 < -17'sd20480)
        begin
            o_clamp = -16'sd20480;
        end
        else
        begin
            o_clamp = o17[TGT_W-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        s_next         = s_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: if (!q_status.empty) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  state_next = ST_TGT;
            ST_TGT:  state_next = ST_SLEW;
            ST_SLEW: state_next = ST_OUT;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next     = ST_IDLE;
                    s_next         = s_sat;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            s_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            sel_reg     <= job_sel;
            present_reg <= job_present;
            k_reg       <= (job_knob > ONE_Q16) ? ONE_Q16 : job_knob;
            cv_reg      <= $signed(job_cv);
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= $signed({1'b0, k_reg}) * cv_reg;
        end
        if (state_reg == ST_DIV)
        begin
            v_reg <= present_reg ? v_calc : k_reg;
        end
        if (state_reg == ST_TGT)
        begin
            target_reg <= target_calc;
        end
        if (state_reg == ST_SLEW)
        begin
            slew_reg <= slew_calc;
        end
        if (finish)
        begin
            out_level_reg <= SAMPLE_BITS'(o_clamp);
            out_ch_reg    <= sel_reg;
            out_lamp_reg  <= LAMP_W'(1) << sel_reg;
        end
    end

    assign empty          = !out_valid_reg;
    assign out_level      = out_level_reg;
    assign active_channel = out_ch_reg;
    assign lamp_mask      = out_lamp_reg;

endmodule

// ----- sv/trigger_select_cv_slew.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake              | Payload
// ----------+-----------+------------------------+-------------------------------------------
// input     | in        | push / full            | channel, trigger_level, cv_level,
//           |           |                        | cv_present, knob_level, frame_end
// result    | out       | empty / pop            | out_level, active_channel, lamp_mask
// config    | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The front end takes one input transfer per cycle while full is low; an item that
// closes a frame queues one job (2-deep queue). The back end works on one job at a
// time, in order: take, CV multiply, divide by 20480, range scaling, slew multiply,
// saturate and output. A result shows once its job has passed these steps and the
// output slot is free, so the front end keeps taking items while the back end works
// until the job queue fills. Reset is asynchronous, active low, and leaves channel
// zero selected and the smoothed value at zero. full rises only when the job queue
// is full; the back end holds a finished result while the output slot is occupied.
module trigger_select_cv_slew
    import tscs_pkg::*;
#(
    parameter int CHANNELS    = CHANNELS_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [CH_W-1:0]               channel,
    input  logic signed [SAMPLE_BITS-1:0] trigger_level,
    input  logic signed [SAMPLE_BITS-1:0] cv_level,
    input  logic                          cv_present,
    input  logic [KNOB_W-1:0]             knob_level,
    input  logic                          frame_end,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [SAMPLE_BITS-1:0] out_level,
    output logic [CH_W-1:0]               active_channel,
    output logic [LAMP_W-1:0]             lamp_mask,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int JOB_W = CH_W + 1 + KNOB_W + SAMPLE_BITS;

    logic [MODE_W-1:0]   range_mode_reg, range_mode_next;
    logic [FACTOR_W-1:0] smoothing_reg, smoothing_next;
    fifo_status_t        q_status;
    logic                job_push, job_take;
    logic [JOB_W-1:0]    job_in, job_out;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        range_mode_next = range_mode_reg;
        smoothing_next  = smoothing_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RANGE_MODE: range_mode_next = cfg_data[MODE_W-1:0];
                REG_SMOOTHING:  smoothing_next  = cfg_data[FACTOR_W-1:0];
                default:        range_mode_next = range_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_mode_reg <= MODE_UNIPOLAR;
            smoothing_reg  <= ONE_Q16;
        end
        else
        begin
            range_mode_reg <= range_mode_next;
            smoothing_reg  <= smoothing_next;
        end
    end

    // Front end: stores and trigger selection
    tscs_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .channel       (channel),
        .trigger_level (trigger_level),
        .cv_level      (cv_level),
        .cv_present    (cv_present),
        .knob_level    (knob_level),
        .frame_end     (frame_end),
        .q_status      (q_status),
        .full          (full),
        .job_push      (job_push),
        .job_data      (job_in)
    );

    // Job queue
    tscs_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_take),
        .rd_data (job_out),
        .status  (q_status)
    );

    // Back end: scaling, slew and output slot
    tscs_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_status         (q_status),
        .job_data         (job_out),
        .job_take         (job_take),
        .range_mode       (range_mode_reg),
        .smoothing_factor (smoothing_reg),
        .pop              (pop),
        .empty            (empty),
        .out_level        (out_level),
        .active_channel   (active_channel),
        .lamp_mask        (lamp_mask)
    );

endmodule

// ----- sv/tscs_checker.sv -----
`timescale 1ns / 1ps
module tscs_checker
    import tscs_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   pop,
    input logic                   empty,
    input logic [SAMPLE_BITS-1:0] out_level,
    input logic [CH_W-1:0]        active_channel,
    input logic [LAMP_W-1:0]      lamp_mask
);

    // Reset clears the result slot
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result shown during reset");

    // Lamp mask follows the channel shown
    a_lamp_match: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (lamp_mask == (LAMP_W'(1) << active_channel)) && $onehot(lamp_mask))
        else $error("lamp mask does not match active channel");

    // A waiting result goes away only through a pop transfer
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result dropped without transfer");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_level) && $stable(active_channel))
        else $error("stalled result changed");

endmodule

bind trigger_select_cv_slew tscs_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tscs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .pop            (pop),
    .empty          (empty),
    .out_level      (out_level),
    .active_channel (active_channel),
    .lamp_mask      (lamp_mask)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import tscs_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int S_MAX       = (1 << (SW - 1)) - 1;
    localparam int S_MIN       = -(1 << (SW - 1));
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE      = 12;
    localparam int PHASE_ITEMS = 130;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0]      ch;
        logic signed [SW-1:0] trig;
        logic signed [SW-1:0] cv;
        logic                 pres;
        logic [KNOB_W-1:0]    knob;
        logic                 fend;
    } chan_item_t;

    typedef struct packed {
        logic signed [SW-1:0] level;
        logic [CH_W-1:0]      ch;
        logic [LAMP_W-1:0]    lamp;
    } frame_result_t;

    // Channel selector / slew predictor plus the queue of expected frame results
    class slew_scoreboard;
        logic [MODE_W-1:0]    mode;
        logic [FACTOR_W-1:0]  factor;
        logic [CH_W-1:0]      active;
        logic signed [SW-1:0] cv_mem [CHANNELS_DEF];
        logic                 pres_mem [CHANNELS_DEF];
        logic [KNOB_W-1:0]    knob_mem [CHANNELS_DEF];
        bit                   best_found;
        logic [CH_W-1:0]      best_ch;
        longint               smooth;
        frame_result_t        frames_q[$];
        int                   errors;

        function new();
            mode       = MODE_UNIPOLAR;
            factor     = ONE_Q16;
            active     = '0;
            best_found = 0;
            best_ch    = '0;
            smooth     = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_RANGE_MODE)
                mode = data[MODE_W-1:0];
            else
                factor = data[FACTOR_W-1:0];
        endfunction

        function int pending();
            return frames_q.size();
        endfunction

        // One accepted input transfer
        function void note_item(chan_item_t it);
            longint k, v, prod, target, f, diff, o;
            frame_result_t res;
            cv_mem[it.ch]   = it.cv;
            pres_mem[it.ch] = it.pres;
            knob_mem[it.ch] = it.knob;
            if (it.trig > TRIG_THRESHOLD && (!best_found || it.ch > best_ch)) begin
                best_ch    = it.ch;
                best_found = 1;
            end
            if (!it.fend)
                return;

            // frame closes: latch the highest triggered channel, else hold
            if (best_found)
                active = best_ch;
            best_found = 0;
            best_ch    = '0;

            k = longint'(knob_mem[active]);
            if (k > longint'(ONE_Q16))
                k = longint'(ONE_Q16);
            if (pres_mem[active]) begin
                // negative products clamp to zero either way
                prod = k * longint'(cv_mem[active]);
                v = (prod <= 0) ? 0 : prod / OUT_LIMIT;
                if (v > longint'(ONE_Q16))
                    v = longint'(ONE_Q16);
            end else begin
                v = k;
            end

            // range scaling
            if (mode == MODE_UNIT) begin
                target = (v + 16) >>> 5;
            end else begin
                target = (v * OUT_LIMIT + 32768) >>> 16;
                if (mode == MODE_BIPOLAR)
                    target -= OUT_LIMIT / 2;
            end

            // one-pole slew
            f = (factor > ONE_Q16) ? longint'(ONE_Q16) : longint'(factor);
            diff = target * 65536 - smooth;
            smooth = smooth + ((diff * f) >>> 16);
            if (smooth > 64'sd2147483647)
                smooth = 64'sd2147483647;
            if (smooth < -64'sd2147483648)
                smooth = -64'sd2147483648;

            o = (smooth + 32768) >>> 16;
            if (o > OUT_LIMIT)
                o = OUT_LIMIT;
            if (o < -OUT_LIMIT)
                o = -OUT_LIMIT;

            res.level = o[SW-1:0];
            res.ch    = active;
            res.lamp  = LAMP_W'(1) << active;
            frames_q.push_back(res);
        endfunction

        // One accepted result transfer
        function void check_frame(logic signed [SW-1:0] level, logic [CH_W-1:0] ch,
                                  logic [LAMP_W-1:0] lamp);
            frame_result_t exp_res;
            if (frames_q.size() == 0) begin
                $error("result with none pending: out_level %0d active_channel %0d lamp_mask %h",
                       level, ch, lamp);
                errors++;
                return;
            end
            exp_res = frames_q.pop_front();
            if (level !== exp_res.level) begin
                $error("out_level: expected %0d, actual %0d", exp_res.level, level);
                errors++;
            end
            if (ch !== exp_res.ch) begin
                $error("active_channel: expected %0d, actual %0d", exp_res.ch, ch);
                errors++;
            end
            if (lamp !== exp_res.lamp) begin
                $error("lamp_mask: expected %h, actual %h", exp_res.lamp, lamp);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    logic [CH_W-1:0]       channel;
    logic signed [SW-1:0]  trigger_level;
    logic signed [SW-1:0]  cv_level;
    logic                  cv_present;
    logic [KNOB_W-1:0]     knob_level;
    logic                  frame_end;
    logic                  empty;
    logic                  pop;
    logic signed [SW-1:0]  out_level;
    logic [CH_W-1:0]       active_channel;
    logic [LAMP_W-1:0]     lamp_mask;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    slew_scoreboard sb;
    int in_run;
    int out_run;
    int cycle_count;

    trigger_select_cv_slew DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .channel        (channel),
        .trigger_level  (trigger_level),
        .cv_level       (cv_level),
        .cv_present     (cv_present),
        .knob_level     (knob_level),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .out_level      (out_level),
        .active_channel (active_channel),
        .lamp_mask      (lamp_mask),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle cycles before a transfer; occasional runs with no idling
    function automatic int draw_wait(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic chan_item_t mk_item(int ch, int trig, int cv, bit pres, int knob, bit fend);
        chan_item_t it;
        it.ch   = CH_W'(ch);
        it.trig = SW'(trig);
        it.cv   = SW'(cv);
        it.pres = pres;
        it.knob = KNOB_W'(knob);
        it.fend = fend;
        return it;
    endfunction

    function automatic logic signed [SW-1:0] rand_trig(bit hi);
        if (hi)
        begin
            case ($urandom_range(0, 3))
                0:       return SW'(TRIG_THRESHOLD + 1);
                1:       return SW'(S_MAX);
                default: return SW'($urandom_range(TRIG_THRESHOLD + 1, S_MAX));
            endcase
        end
        case ($urandom_range(0, 3))
            0:       return SW'(TRIG_THRESHOLD);
            1:       return SW'(S_MIN);
            default: return SW'($urandom_range(0, TRIG_THRESHOLD - S_MIN) + S_MIN);
        endcase
    endfunction

    function automatic logic signed [SW-1:0] rand_cv();
        case ($urandom_range(0, 7))
            0:       return SW'(S_MAX);
            1:       return SW'(S_MIN);
            2, 3:    return SW'($urandom);
            default: return SW'($urandom_range(0, OUT_LIMIT + 4096));
        endcase
    endfunction

    function automatic logic [KNOB_W-1:0] rand_knob();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ONE_Q16;
            2:       return KNOB_W'($urandom_range(65537, 131071));
            default: return KNOB_W'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [FACTOR_W-1:0] rand_factor();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return FACTOR_W'(1);
            2:       return ONE_Q16;
            3:       return FACTOR_W'($urandom_range(65537, 131071));
            4:       return FACTOR_W'(65535);
            default: return FACTOR_W'($urandom_range(256, 65536));
        endcase
    endfunction

    // Register write on the config channel
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Drain all pending frames, then let the back end settle
    task automatic wait_idle();
        push <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [MODE_W-1:0] mode, input logic [FACTOR_W-1:0] factor);
        wait_idle();
        write_reg(REG_RANGE_MODE, CFG_DATA_W'(mode));
        @(posedge clk);
        write_reg(REG_SMOOTHING, CFG_DATA_W'(factor));
    endtask

    // One input transfer; push stays high across back-to-back items
    task automatic send_item(input chan_item_t it);
        int gap;
        gap = draw_wait(in_run);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push          <= 1'b1;
        channel       <= it.ch;
        trigger_level <= it.trig;
        cv_level      <= it.cv;
        cv_present    <= it.pres;
        knob_level    <= it.knob;
        frame_end     <= it.fend;
        do
            @(posedge clk);
        while (full);
        sb.note_item(it);
    endtask

    // Random frames; mostly well-formed, some with stray frame ends
    task automatic run_frames(input int n_items);
        int sent;
        int len;
        int style;
        int first;
        int fire;
        chan_item_t it;
        sent = 0;
        while (sent < n_items)
        begin
            len   = $urandom_range(1, CHANNELS_DEF);
            style = $urandom_range(0, 9);
            first = $urandom_range(0, CHANNELS_DEF - 1);
            fire  = $urandom_range(0, 3);
            for (int i = 0; i < len; i++)
            begin
                if (style < 6)
                    it.ch = CH_W'(i);
                else if (style < 8)
                    it.ch = CH_W'((first + i) % CHANNELS_DEF);
                else
                    it.ch = CH_W'($urandom_range(0, CHANNELS_DEF - 1));
                it.trig = rand_trig(fire == 3 || (fire > 0 && $urandom_range(0, 3) < fire));
                it.cv   = rand_cv();
                it.pres = 1'($urandom_range(0, 1));
                it.knob = rand_knob();
                it.fend = (i == len - 1) || (style == 9 && $urandom_range(0, 3) == 0);
                send_item(it);
                sent++;
            end
        end
    endtask

    // Result side: random stalls on pop
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(out_run);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            sb.check_frame(out_level, active_channel, lamp_mask);
        end
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        sb            = new();
        in_run        = 0;
        out_run       = 0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        channel       = '0;
        trigger_level = '0;
        cv_level      = '0;
        cv_present    = 1'b0;
        knob_level    = '0;
        frame_end     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_RANGE_MODE;
        cfg_data      = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: selection rules, knob and CV extremes, snap factor
        apply_setting(MODE_UNIPOLAR, ONE_Q16);
        send_item(mk_item(0, 0, 0, 0, 65536, 0));
        send_item(mk_item(0, TRIG_THRESHOLD, 0, 0, 65536, 1));        // at threshold: hold
        send_item(mk_item(7, TRIG_THRESHOLD + 1, 0, 0, 131071, 1));   // knob saturates
        send_item(mk_item(3, S_MAX, S_MAX, 1, 65536, 0));
        send_item(mk_item(5, S_MAX, S_MIN, 1, 65536, 0));
        send_item(mk_item(2, 5000, 100, 1, 100, 1));                  // highest wins, not last
        send_item(mk_item(6, 3000, OUT_LIMIT, 1, 32768, 0));
        send_item(mk_item(1, 30000, 0, 0, 1, 1));
        send_item(mk_item(4, S_MIN, 10240, 1, 0, 1));                 // no trigger: hold
        send_item(mk_item(3, TRIG_THRESHOLD + 1, S_MAX, 1, 65536, 1));
        send_item(mk_item(1, 2100, OUT_LIMIT, 1, 65535, 1));
        send_item(mk_item(0, TRIG_THRESHOLD + 1, -1, 1, 65536, 1));   // tiny negative CV
        send_item(mk_item(7, S_MAX, S_MAX, 0, 0, 1));

        // Directed: each range mode, spare mode, factor above one and zero
        apply_setting(MODE_BIPOLAR, ONE_Q16);
        send_item(mk_item(2, TRIG_THRESHOLD + 1, 0, 0, 65536, 1));
        send_item(mk_item(2, 0, 0, 0, 0, 1));
        apply_setting(MODE_UNIT, ONE_Q16);
        send_item(mk_item(2, TRIG_THRESHOLD + 1, 0, 0, 65536, 1));
        send_item(mk_item(2, 0, 0, 0, 31, 1));
        apply_setting(MODE_SPARE, FACTOR_W'(131071));
        send_item(mk_item(4, TRIG_THRESHOLD + 1, 0, 0, 65536, 1));
        send_item(mk_item(4, 0, 0, 0, 0, 1));
        apply_setting(MODE_UNIPOLAR, '0);
        send_item(mk_item(6, TRIG_THRESHOLD + 1, 0, 0, 65536, 1));
        send_item(mk_item(6, 0, 0, 0, 12345, 1));

        // Random frames over fixed and random settings
        apply_setting(MODE_BIPOLAR, ONE_Q16);
        run_frames(PHASE_ITEMS);
        apply_setting(MODE_UNIT, ONE_Q16);
        run_frames(PHASE_ITEMS);
        apply_setting(MODE_SPARE, FACTOR_W'(131071));
        run_frames(PHASE_ITEMS);
        apply_setting(MODE_BIPOLAR, '0);
        run_frames(PHASE_ITEMS);
        apply_setting(MODE_UNIPOLAR, FACTOR_W'(1));
        run_frames(PHASE_ITEMS);
        apply_setting(MODE_UNIT, FACTOR_W'(65537));
        run_frames(PHASE_ITEMS);
        apply_setting(MODE_UNIPOLAR, FACTOR_W'(40000));
        run_frames(PHASE_ITEMS);
        for (int p = 0; p < 8; p++)
        begin
            apply_setting(MODE_W'($urandom_range(0, 3)), rand_factor());
            run_frames(PHASE_ITEMS);
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- trigger_select_cv_slew.f -----
sv/tscs_pkg.sv
sv/tscs_fifo.sv
sv/tscs_front.sv
sv/tscs_back.sv
sv/trigger_select_cv_slew.sv
sv/tscs_checker.sv
sim/tb.sv
